### rtl/core/bpa_pkg.sv
// Shared constants, codes and types of the buddy page allocator.
// Used by bpa_mem, bpa_seq and buddy_page_allocator; no dependencies.
package bpa_pkg;

	// Default geometry
	localparam int PAGES_DEF  = 1024;
	localparam int ORDERS_DEF = 11;

	// Fixed field widths
	localparam int PAGE_SHIFT = 12;
	localparam int AW         = 22;
	localparam int CW         = 11;
	localparam int STW        = 3;
	localparam int ACTW       = 2;

	localparam logic [CW-1:0] CNT_MAX   = '1;
	localparam logic [CW-1:0] CFG_RESET = CW'(1024);

	// Request codes
	localparam logic [ACTW-1:0] ACT_ANY  = 2'd0;
	localparam logic [ACTW-1:0] ACT_AT   = 2'd1;
	localparam logic [ACTW-1:0] ACT_FREE = 2'd2;

	// Status codes
	localparam logic [STW-1:0] ST_OK       = 3'd0;
	localparam logic [STW-1:0] ST_MISALIGN = 3'd1;
	localparam logic [STW-1:0] ST_RANGE    = 3'd2;
	localparam logic [STW-1:0] ST_STATE    = 3'd3;
	localparam logic [STW-1:0] ST_NOBLOCK  = 3'd4;

	// Register indexes
	localparam logic REG_PAGES = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	// Write enables of the page tables
	typedef struct packed {
		logic alloc;
		logic ord;
		logic nxt;
		logic prv;
	} mem_we_t;

endpackage

### rtl/core/bpa_mem.sv
// Page tables: allocated bit, free-block order and list links per page.
// One read address shared by all tables, with registered read data; a write port per table.
// Depends on bpa_pkg.
module bpa_mem #(
	parameter int PAGES = bpa_pkg::PAGES_DEF,
	parameter int ORDERS = bpa_pkg::ORDERS_DEF,
	localparam int IW = $clog2(PAGES),
	localparam int LW = IW + 1,
	localparam int OW = $clog2(ORDERS + 1)
) (
	input  logic            clk,
	input  bpa_pkg::mem_we_t we,
	input  logic [IW-1:0]   alloc_addr,
	input  logic            alloc_d,
	input  logic [IW-1:0]   ord_addr,
	input  logic [OW-1:0]   ord_d,
	input  logic [IW-1:0]   nxt_addr,
	input  logic [LW-1:0]   nxt_d,
	input  logic [IW-1:0]   prv_addr,
	input  logic [LW-1:0]   prv_d,
	input  logic [IW-1:0]   rd_addr,
	output logic            rd_alloc,
	output logic [OW-1:0]   rd_ord,
	output logic [LW-1:0]   rd_nxt,
	output logic [LW-1:0]   rd_prv
);
	import bpa_pkg::*;

	logic          alloc_mem [PAGES];
	logic [OW-1:0] ord_mem [PAGES];
	logic [LW-1:0] nxt_mem [PAGES];
	logic [LW-1:0] prv_mem [PAGES];

	// Write ports
	always_ff @(posedge clk) begin
		if (we.alloc) begin
			alloc_mem[alloc_addr] <= alloc_d;
		end
		if (we.ord) begin
			ord_mem[ord_addr] <= ord_d;
		end
		if (we.nxt) begin
			nxt_mem[nxt_addr] <= nxt_d;
		end
		if (we.prv) begin
			prv_mem[prv_addr] <= prv_d;
		end
	end

	// Registered read of all tables at one page
	always_ff @(posedge clk) begin
		rd_alloc <= alloc_mem[rd_addr];
		rd_ord   <= ord_mem[rd_addr];
		rd_nxt   <= nxt_mem[rd_addr];
		rd_prv   <= prv_mem[rd_addr];
	end

endmodule

### rtl/core/bpa_seq.sv
// Request sequencer: walks free lists, splits and merges blocks through
// one table read or write step per cycle. Holds list heads and free count.
// Depends on bpa_pkg.
module bpa_seq #(
	parameter int PAGES = bpa_pkg::PAGES_DEF,
	parameter int ORDERS = bpa_pkg::ORDERS_DEF,
	localparam int IW = $clog2(PAGES),
	localparam int LW = IW + 1,
	localparam int OW = $clog2(ORDERS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bpa_pkg::CW-1:0]   pages_in_use,
	input  logic [bpa_pkg::CW-1:0]   alloc_limit_pages,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [bpa_pkg::ACTW-1:0] action,
	input  logic [bpa_pkg::AW-1:0]   byte_address,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [bpa_pkg::AW-1:0]   res_addr,
	output logic [bpa_pkg::STW-1:0]  res_status,
	output logic [bpa_pkg::CW-1:0]   res_count,
	output bpa_pkg::mem_we_t         we,
	output logic [IW-1:0]            alloc_addr,
	output logic                     alloc_d,
	output logic [IW-1:0]            ord_addr,
	output logic [OW-1:0]            ord_d,
	output logic [IW-1:0]            nxt_addr,
	output logic [LW-1:0]            nxt_d,
	output logic [IW-1:0]            prv_addr,
	output logic [LW-1:0]            prv_d,
	output logic [IW-1:0]            rd_addr,
	input  logic                     rd_alloc,
	input  logic [OW-1:0]            rd_ord,
	input  logic [LW-1:0]            rd_nxt,
	input  logic [LW-1:0]            rd_prv
);
	import bpa_pkg::*;

	localparam int HW = $clog2(ORDERS);
	localparam int SW = 5;
	localparam logic [LW-1:0] NIL = LW'(PAGES);
	localparam logic [OW-1:0] NOBLK = '1;

	localparam logic [SW-1:0] S_CLR    = 5'd0;
	localparam logic [SW-1:0] S_IDLE   = 5'd1;
	localparam logic [SW-1:0] S_DISP   = 5'd2;
	localparam logic [SW-1:0] S_A_ORD  = 5'd3;
	localparam logic [SW-1:0] S_A_CHK  = 5'd4;
	localparam logic [SW-1:0] S_A_NXT  = 5'd5;
	localparam logic [SW-1:0] S_A_SPL  = 5'd6;
	localparam logic [SW-1:0] S_T_RD   = 5'd7;
	localparam logic [SW-1:0] S_T_ISS  = 5'd8;
	localparam logic [SW-1:0] S_T_CMP  = 5'd9;
	localparam logic [SW-1:0] S_T_SPL  = 5'd10;
	localparam logic [SW-1:0] S_F_RD   = 5'd11;
	localparam logic [SW-1:0] S_F_LOOP = 5'd12;
	localparam logic [SW-1:0] S_F_CMP  = 5'd13;
	localparam logic [SW-1:0] S_F_MRG  = 5'd14;
	localparam logic [SW-1:0] S_P0     = 5'd15;
	localparam logic [SW-1:0] S_P1     = 5'd16;
	localparam logic [SW-1:0] S_U0     = 5'd17;
	localparam logic [SW-1:0] S_U1     = 5'd18;
	localparam logic [SW-1:0] S_U2     = 5'd19;
	localparam logic [SW-1:0] S_TAKE   = 5'd20;
	localparam logic [SW-1:0] S_DONE   = 5'd21;

	logic [SW-1:0]   state_q, ret_q;
	logic [ACTW-1:0] act_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   res_addr_q;
	logic [STW-1:0]  st_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   clr_q;
	logic [IW-1:0]   pg_q, b_q, sub_pg_q;
	logic [LW-1:0]   it_q;
	logic [IW:0]     steps_q;
	logic [OW-1:0]   o_q, fo_q, co_q, sub_o_q;
	logic            found_q;
	logic [LW-1:0]   head_q [ORDERS];

	logic [CW-1:0]         used, lim;
	logic [OW-1:0]         top, f1;
	logic [AW-PAGE_SHIFT-1:0] req_pg_full;
	logic [IW-1:0]         req_pg, s_blk, bud, right, split_pg;
	logic                  misal, fits;
	logic [LW-1:0]         head_o, sub_head;

	// Effective page count, search limit and top order
	always_comb begin
		used = (32'(pages_in_use) > PAGES) ? CW'(PAGES) : pages_in_use;
		lim  = (alloc_limit_pages < used) ? alloc_limit_pages : used;
		top  = '0;
		for (int k = 1; k < ORDERS; k++) begin
			if ((32'(1) << k) <= 32'(used)) begin
				top = OW'(k);
			end
		end
	end

	// Address decode and step arithmetic
	always_comb begin
		req_pg_full = addr_q[AW-1:PAGE_SHIFT];
		req_pg      = IW'(32'(req_pg_full));
		misal       = |addr_q[PAGE_SHIFT-1:0];
		f1          = fo_q - 1'b1;
		fits        = (32'(it_q) + (32'(1) << o_q)) <= 32'(lim);
		s_blk       = IW'((32'(pg_q) >> o_q) << o_q);
		bud         = pg_q ^ IW'(32'(1) << co_q);
		right       = IW'(32'(it_q) + (32'(1) << f1));
		split_pg    = IW'(32'(pg_q) + (32'(1) << f1));
		head_o      = head_q[o_q[HW-1:0]];
		sub_head    = head_q[sub_o_q[HW-1:0]];
	end

	// Table read address
	always_comb begin
		case (state_q)
			S_DISP:   rd_addr = req_pg;
			S_A_CHK:  rd_addr = it_q[IW-1:0];
			S_T_ISS:  rd_addr = s_blk;
			S_F_LOOP: rd_addr = bud;
			S_U0:     rd_addr = sub_pg_q;
			default:  rd_addr = '0;
		endcase
	end

	// Table writes
	always_comb begin
		we         = '0;
		alloc_addr = pg_q;
		alloc_d    = 1'b1;
		ord_addr   = sub_pg_q;
		ord_d      = NOBLK;
		nxt_addr   = sub_pg_q;
		nxt_d      = NIL;
		prv_addr   = sub_pg_q;
		prv_d      = NIL;
		case (state_q)
			S_CLR: begin
				we.alloc   = 1'b1;
				alloc_addr = clr_q;
				we.ord     = 1'b1;
				ord_addr   = clr_q;
			end
			S_TAKE: begin
				we.alloc = 1'b1;
			end
			S_F_RD: begin
				we.alloc = rd_alloc;
				alloc_d  = 1'b0;
			end
			S_P0: begin
				we.ord = 1'b1;
				ord_d  = sub_o_q;
				we.nxt = 1'b1;
				nxt_d  = sub_head;
				we.prv = 1'b1;
			end
			S_P1: begin
				we.prv   = 32'(sub_head) < PAGES;
				prv_addr = sub_head[IW-1:0];
				prv_d    = LW'(sub_pg_q);
			end
			S_U1: begin
				we.nxt   = 32'(rd_prv) < PAGES;
				nxt_addr = rd_prv[IW-1:0];
				nxt_d    = rd_nxt;
				we.prv   = 32'(rd_nxt) < PAGES;
				prv_addr = rd_nxt[IW-1:0];
				prv_d    = (32'(rd_prv) < PAGES) ? rd_prv : NIL;
			end
			S_U2: begin
				we.ord = 1'b1;
				we.nxt = 1'b1;
				we.prv = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= S_IDLE;
			clr_q   <= '0;
			cnt_q   <= '0;
			for (int k = 0; k < ORDERS; k++) begin
				head_q[k] <= NIL;
			end
		end else begin
			case (state_q)
				// sweep reset values into the tables
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == PAGES - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						act_q      <= action;
						addr_q     <= byte_address;
						st_q       <= ST_OK;
						res_addr_q <= '0;
						state_q    <= S_DISP;
					end
				end
				// early checks and first table read
				S_DISP: begin
					case (act_q)
						ACT_ANY: begin
							o_q <= '0;
							if (lim == '0) begin
								st_q    <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_A_ORD;
							end
						end
						ACT_AT: begin
							pg_q <= req_pg;
							if (misal) begin
								st_q    <= ST_MISALIGN;
								state_q <= S_DONE;
							end else if (32'(req_pg_full) >= 32'(alloc_limit_pages) ||
							             32'(req_pg_full) >= 32'(used)) begin
								st_q    <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_T_RD;
							end
						end
						ACT_FREE: begin
							pg_q <= req_pg;
							if (misal) begin
								st_q    <= ST_MISALIGN;
								state_q <= S_DONE;
							end else if (32'(req_pg_full) >= 32'(used)) begin
								st_q    <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_F_RD;
							end
						end
						default: begin
							st_q    <= ST_RANGE;
							state_q <= S_DONE;
						end
					endcase
				end
				// allocate any: next order's list
				S_A_ORD: begin
					if (o_q > top) begin
						st_q    <= ST_NOBLOCK;
						state_q <= S_DONE;
					end else begin
						it_q    <= head_o;
						steps_q <= '0;
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (32'(it_q) >= PAGES || 32'(steps_q) == PAGES) begin
						o_q     <= o_q + 1'b1;
						state_q <= S_A_ORD;
					end else if (fits) begin
						pg_q       <= it_q[IW-1:0];
						fo_q       <= o_q;
						res_addr_q <= AW'(32'(it_q) << PAGE_SHIFT);
						sub_o_q    <= o_q;
						sub_pg_q   <= it_q[IW-1:0];
						ret_q      <= S_A_SPL;
						state_q    <= S_U0;
					end else begin
						state_q <= S_A_NXT;
					end
				end
				S_A_NXT: begin
					it_q    <= rd_nxt;
					steps_q <= steps_q + 1'b1;
					state_q <= S_A_CHK;
				end
				// push the upper halves down to one page
				S_A_SPL: begin
					if (fo_q == '0) begin
						state_q <= S_TAKE;
					end else begin
						fo_q     <= f1;
						sub_o_q  <= f1;
						sub_pg_q <= split_pg;
						ret_q    <= S_A_SPL;
						state_q  <= S_P0;
					end
				end
				// allocate at address
				S_T_RD: begin
					if (rd_alloc) begin
						st_q    <= ST_STATE;
						state_q <= S_DONE;
					end else begin
						o_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_T_ISS;
					end
				end
				S_T_ISS: begin
					if (o_q > top) begin
						if (!found_q) begin
							st_q    <= ST_NOBLOCK;
							state_q <= S_DONE;
						end else begin
							sub_o_q  <= fo_q;
							sub_pg_q <= it_q[IW-1:0];
							ret_q    <= S_T_SPL;
							state_q  <= S_U0;
						end
					end else if (32'(s_blk) >= 32'(used)) begin
						o_q <= o_q + 1'b1;
					end else begin
						b_q     <= s_blk;
						state_q <= S_T_CMP;
					end
				end
				S_T_CMP: begin
					if (rd_ord == o_q) begin
						found_q <= 1'b1;
						fo_q    <= o_q;
						it_q    <= LW'(b_q);
					end
					o_q     <= o_q + 1'b1;
					state_q <= S_T_ISS;
				end
				// split toward the target page
				S_T_SPL: begin
					if (fo_q == '0) begin
						res_addr_q <= addr_q;
						state_q    <= S_TAKE;
					end else begin
						fo_q    <= f1;
						sub_o_q <= f1;
						if (pg_q >= right) begin
							sub_pg_q <= it_q[IW-1:0];
							it_q     <= LW'(right);
						end else begin
							sub_pg_q <= right;
						end
						ret_q   <= S_T_SPL;
						state_q <= S_P0;
					end
				end
				// free: release the page, then merge upward
				S_F_RD: begin
					if (!rd_alloc) begin
						st_q    <= ST_STATE;
						state_q <= S_DONE;
					end else begin
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						co_q    <= '0;
						state_q <= S_F_LOOP;
					end
				end
				S_F_LOOP: begin
					if (co_q < top && 32'(bud) < 32'(used)) begin
						b_q     <= bud;
						state_q <= S_F_CMP;
					end else begin
						sub_o_q  <= co_q;
						sub_pg_q <= pg_q;
						ret_q    <= S_DONE;
						state_q  <= S_P0;
					end
				end
				S_F_CMP: begin
					if (rd_ord == co_q) begin
						sub_o_q  <= co_q;
						sub_pg_q <= b_q;
						ret_q    <= S_F_MRG;
						state_q  <= S_U0;
					end else begin
						sub_o_q  <= co_q;
						sub_pg_q <= pg_q;
						ret_q    <= S_DONE;
						state_q  <= S_P0;
					end
				end
				S_F_MRG: begin
					if (b_q < pg_q) begin
						pg_q <= b_q;
					end
					co_q    <= co_q + 1'b1;
					state_q <= S_F_LOOP;
				end
				// push block onto its list head
				S_P0: begin
					state_q <= S_P1;
				end
				S_P1: begin
					head_q[sub_o_q[HW-1:0]] <= LW'(sub_pg_q);
					state_q <= ret_q;
				end
				// unlink block from its list
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					if (32'(rd_prv) >= PAGES) begin
						head_q[sub_o_q[HW-1:0]] <= (32'(rd_nxt) < PAGES) ? rd_nxt : NIL;
					end
					state_q <= S_U2;
				end
				S_U2: begin
					state_q <= ret_q;
				end
				S_TAKE: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				// hold the result until the output stage takes it
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_addr   = (st_q == ST_OK) ? res_addr_q : '0;
	assign res_status = st_q;
	assign res_count  = cnt_q;

endmodule

### rtl/core/buddy_page_allocator.sv
// Buddy page allocator: one request in on the slave stream, one result out
// on the master stream, one page-table step per clock cycle while a request is processed.
//
// Input transfer: tuser carries the request (0 allocate any page, 1 allocate
// at an address, 2 free a page), tdata the byte address. Output transfer:
// tdata carries page address, status and free-page count.
// Registers pages_in_use and alloc_limit_pages are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while no request is in flight, the block does not enforce this.
// After reset the block sweeps all PAGES entries (1024 by default) of its page tables
// with s_tready low; then every page counts as allocated and all
// free lists are empty, and software frees pages to fill them.
// A rejected request passes through the accept, decode and result states (S_IDLE,
// S_DISP, S_DONE), and its result shows on the master stream in the cycle after the
// sequencer leaves S_DONE. Longer requests add one pass through the page tables per step:
// a list step (S_A_CHK, S_A_NXT), an order probe (S_T_ISS, S_T_CMP), a push (S_P0, S_P1)
// or an unlink (S_U0, S_U1, S_U2); an allocation adds a push per split order plus its list
// walk or probes, and a free a buddy check, an unlink and a merge step per merged order.
// One request is in flight at a time.
// A finished result sits in the output register; when the receiver
// stalls, the block holds it there and stops accepting after the next
// request completes.
// Depends on bpa_pkg, bpa_mem and bpa_seq.
module buddy_page_allocator #(
	parameter int PAGES = bpa_pkg::PAGES_DEF,
	parameter int ORDERS = bpa_pkg::ORDERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [bpa_pkg::CW-1:0] cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // byte_address[21:0], zero pad
	input  logic [1:0]             s_tuser,   // action[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [39:0]            m_tdata    // page_address[21:0], status[24:22],
	                                          // free_count[35:25], zero pad
);
	import bpa_pkg::*;

	localparam int IW = $clog2(PAGES);
	localparam int LW = IW + 1;
	localparam int OW = $clog2(ORDERS + 1);

	logic [CW-1:0]  pages_q, limit_q;
	logic           res_valid, res_ready;
	logic [AW-1:0]  res_addr;
	logic [STW-1:0] res_status;
	logic [CW-1:0]  res_count;
	mem_we_t        we;
	logic [IW-1:0]  alloc_addr, ord_addr, nxt_addr, prv_addr, rd_addr;
	logic           alloc_d, rd_alloc;
	logic [OW-1:0]  ord_d, rd_ord;
	logic [LW-1:0]  nxt_d, prv_d, rd_nxt, rd_prv;
	logic           m_tvalid_q;
	logic [39:0]    m_tdata_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= CFG_RESET;
			limit_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PAGES: pages_q <= cfg_wdata;
				REG_LIMIT: limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	bpa_seq #(
		.PAGES(PAGES),
		.ORDERS(ORDERS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.pages_in_use(pages_q),
		.alloc_limit_pages(limit_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.action(s_tuser),
		.byte_address(s_tdata[AW-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_addr(res_addr),
		.res_status(res_status),
		.res_count(res_count),
		.we(we),
		.alloc_addr(alloc_addr),
		.alloc_d(alloc_d),
		.ord_addr(ord_addr),
		.ord_d(ord_d),
		.nxt_addr(nxt_addr),
		.nxt_d(nxt_d),
		.prv_addr(prv_addr),
		.prv_d(prv_d),
		.rd_addr(rd_addr),
		.rd_alloc(rd_alloc),
		.rd_ord(rd_ord),
		.rd_nxt(rd_nxt),
		.rd_prv(rd_prv)
	);

	bpa_mem #(
		.PAGES(PAGES),
		.ORDERS(ORDERS)
	) u_mem (
		.clk(clk),
		.we(we),
		.alloc_addr(alloc_addr),
		.alloc_d(alloc_d),
		.ord_addr(ord_addr),
		.ord_d(ord_d),
		.nxt_addr(nxt_addr),
		.nxt_d(nxt_d),
		.prv_addr(prv_addr),
		.prv_d(prv_d),
		.rd_addr(rd_addr),
		.rd_alloc(rd_alloc),
		.rd_ord(rd_ord),
		.rd_nxt(rd_nxt),
		.rd_prv(rd_prv)
	);

	// Output register: load a result whenever it is empty or draining
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {4'b0, res_count, res_status, res_addr};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### tb/tb_buddy_page_allocator.sv
// Self-checking testbench of buddy_page_allocator: directed and random requests with idle
// gaps on both streams, checked against an in-bench model of the buddy lists.
// Depends on bpa_pkg and the allocator RTL.
module tb_buddy_page_allocator;
	import bpa_pkg::*;

	localparam int NPG = 1024;
	localparam int NORD = 11;
	localparam int NIL = NPG;
	localparam logic [3:0] NO_ORD = 4'hF;
	localparam logic [ACTW-1:0] ACT_BAD = 2'd3;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [ACTW-1:0] act;
		logic [AW-1:0]   addr;
	} req_t;

	typedef struct packed {
		logic [AW-1:0]  page_addr;
		logic [STW-1:0] status;
		logic [CW-1:0]  free_cnt;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_addr = 1'b0;
	logic [CW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;

	buddy_page_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Allocator image
	int       mdl_pages, mdl_limit;
	bit       pg_taken [NPG];
	bit [3:0] blk_ord [NPG];
	int       nxt [NPG];
	int       prv [NPG];
	int       heads [NORD];
	int       free_cnt_mdl;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   n_errors = 0;

	function automatic int span();
		return mdl_pages > NPG ? NPG : mdl_pages;
	endfunction

	function automatic int top_ord();
		int o = 0;
		while (o + 1 < NORD && (1 << (o + 1)) <= span())
			o++;
		return o;
	endfunction

	function automatic void push_blk(int o, int pg);
		if (pg >= NPG || o >= NORD)
			return;
		blk_ord[pg] = 4'(o);
		prv[pg] = NIL;
		nxt[pg] = heads[o];
		if (heads[o] < NPG)
			prv[heads[o]] = pg;
		heads[o] = pg;
	endfunction

	function automatic void unlink_blk(int o, int pg);
		int p, n;
		p = prv[pg];
		n = nxt[pg];
		if (p < NPG)
			nxt[p] = n;
		else
			heads[o] = n < NPG ? n : NIL;
		if (n < NPG)
			prv[n] = p < NPG ? p : NIL;
		prv[pg] = NIL;
		nxt[pg] = NIL;
		blk_ord[pg] = NO_ORD;
	endfunction

	function automatic void take_pg(int pg);
		pg_taken[pg] = 1'b1;
		if (free_cnt_mdl > 0)
			free_cnt_mdl--;
	endfunction

	// Apply one request to the image and return its response
	function automatic rsp_t apply_request(req_t r);
		rsp_t rs;
		int pg, lim, top, it, steps, co, fo, start, right, b;
		bit found;
		rs.page_addr = '0;
		rs.status = ST_OK;
		pg = int'(r.addr) >> PAGE_SHIFT;
		top = top_ord();
		case (r.act)
			ACT_ANY: begin
				lim = mdl_limit < span() ? mdl_limit : span();
				rs.status = ST_NOBLOCK;
				if (lim == 0)
					rs.status = ST_RANGE;
				for (int o = 0; o <= top && lim != 0 && rs.status != ST_OK; o++) begin
					it = heads[o];
					steps = 0;
					while (it < NPG && steps < NPG && rs.status != ST_OK) begin
						if (it + (1 << o) <= lim) begin
							unlink_blk(o, it);
							co = o;
							while (co > 0) begin
								co--;
								push_blk(co, it + (1 << co));
							end
							take_pg(it);
							rs.page_addr = AW'(it << PAGE_SHIFT);
							rs.status = ST_OK;
						end else begin
							it = nxt[it];
							steps++;
						end
					end
				end
			end
			ACT_AT: begin
				found = 1'b0;
				fo = 0;
				start = 0;
				if (r.addr[PAGE_SHIFT-1:0] != '0)
					rs.status = ST_MISALIGN;
				else if (pg >= mdl_limit || pg >= span())
					rs.status = ST_RANGE;
				else if (pg_taken[pg])
					rs.status = ST_STATE;
				else begin
					for (int o = 0; o <= top; o++) begin
						b = pg & ~((1 << o) - 1);
						if (b < span() && blk_ord[b] == 4'(o)) begin
							found = 1'b1;
							fo = o;
							start = b;
						end
					end
					if (!found)
						rs.status = ST_NOBLOCK;
					else begin
						unlink_blk(fo, start);
						while (fo > 0) begin
							fo--;
							right = start + (1 << fo);
							if (pg >= right) begin
								push_blk(fo, start);
								start = right;
							end else
								push_blk(fo, right);
						end
						take_pg(pg);
						rs.page_addr = r.addr;
					end
				end
			end
			ACT_FREE: begin
				if (r.addr[PAGE_SHIFT-1:0] != '0)
					rs.status = ST_MISALIGN;
				else if (pg >= span())
					rs.status = ST_RANGE;
				else if (!pg_taken[pg])
					rs.status = ST_STATE;
				else begin
					pg_taken[pg] = 1'b0;
					if (free_cnt_mdl < int'(CNT_MAX))
						free_cnt_mdl++;
					co = 0;
					while (co < top) begin
						b = pg ^ (1 << co);
						if (b >= span() || blk_ord[b] != 4'(co))
							break;
						unlink_blk(co, b);
						if (b < pg)
							pg = b;
						co++;
					end
					push_blk(co, pg);
				end
			end
			default: rs.status = ST_RANGE;
		endcase
		rs.free_cnt = CW'(free_cnt_mdl);
		return rs;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 4)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Driver: feed pending requests, predict each accepted transfer
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_rsps.push_back(apply_request(req_t'({s_tuser, s_tdata[AW-1:0]})));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_t r;
					r = pending_reqs.pop_front();
					s_tuser <= r.act;
					s_tdata <= {2'b00, r.addr};
					s_tvalid <= 1'b1;
					src_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure, compare each result transfer
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rsp_t got, want;
				got = rsp_t'({m_tdata[21:0], m_tdata[24:22], m_tdata[35:25]});
				if (expected_rsps.size() == 0) begin
					$error("unexpected result transfer %h", m_tdata);
					n_errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.page_addr !== want.page_addr) begin
						$error("page_address: expected %h, got %h", want.page_addr, got.page_addr);
						n_errors++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						n_errors++;
					end
					if (got.free_cnt !== want.free_cnt) begin
						$error("free_count: expected %0d, got %0d", want.free_cnt, got.free_cnt);
						n_errors++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_gap <= pick_gap();
			end
		end
	end

	// Watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_buddy_page_allocator: FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= CW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PAGES)
			mdl_pages = val;
		else
			mdl_limit = val;
	endtask

	// Wait on settled signals until every request has been answered
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_tvalid);
		repeat (20) @(posedge clk);
	endtask

	function automatic void add_req(logic [ACTW-1:0] act, logic [AW-1:0] addr);
		req_t r;
		r.act = act;
		r.addr = addr;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [AW-1:0] page_addr_of(int pg);
		return AW'(pg << PAGE_SHIFT);
	endfunction

	// Mostly frees and allocations of pages near the managed range
	task automatic random_phase(int pages, int limit, int count);
		int k, hi;
		write_reg(REG_PAGES, pages);
		write_reg(REG_LIMIT, limit);
		hi = pages > NPG ? NPG - 1 : pages + 3;
		if (hi > NPG - 1)
			hi = NPG - 1;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40)
				add_req(ACT_FREE, page_addr_of($urandom_range(0, hi)));
			else if (k < 70)
				add_req(ACT_ANY, AW'($urandom));
			else if (k < 90)
				add_req(ACT_AT, page_addr_of($urandom_range(0, hi)));
			else
				add_req(2'($urandom_range(0, 3)), AW'($urandom));
		end
		drain();
	endtask

	initial begin
		mdl_pages = 1024;
		mdl_limit = 1024;
		free_cnt_mdl = 0;
		for (int i = 0; i < NPG; i++) begin
			pg_taken[i] = 1'b1;
			blk_ord[i] = NO_ORD;
			nxt[i] = 0;
			prv[i] = 0;
		end
		for (int o = 0; o < NORD; o++)
			heads[o] = NIL;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty lists, bad codes, alignment, state and range errors, frees, merges and allocations
		add_req(ACT_ANY, '0);
		add_req(ACT_BAD, '1);
		add_req(ACT_FREE, 22'h000001);
		add_req(ACT_AT, 22'h000800);
		add_req(ACT_AT, page_addr_of(5));
		add_req(ACT_AT, page_addr_of(6));
		add_req(ACT_FREE, page_addr_of(NPG - 1));
		add_req(ACT_FREE, page_addr_of(NPG - 1));
		add_req(ACT_FREE, page_addr_of(NPG - 2));
		add_req(ACT_AT, page_addr_of(NPG - 1));
		add_req(ACT_FREE, page_addr_of(0));
		add_req(ACT_FREE, page_addr_of(1));
		add_req(ACT_FREE, page_addr_of(2));
		add_req(ACT_FREE, page_addr_of(3));
		add_req(ACT_ANY, '0);
		add_req(ACT_AT, page_addr_of(3));
		add_req(ACT_AT, page_addr_of(3));
		add_req(ACT_ANY, '0);
		add_req(ACT_ANY, '0);
		add_req(ACT_ANY, '0);
		drain();
		write_reg(REG_PAGES, 512);
		add_req(ACT_FREE, page_addr_of(600));
		add_req(ACT_AT, page_addr_of(600));
		drain();

		random_phase(1024, 1024, 400);
		random_phase(512, 300, 250);
		random_phase(2047, 1024, 150);
		random_phase(1, 0, 40);
		random_phase(0, 1024, 40);
		random_phase(1000, 777, 300);
		random_phase(3, 2, 80);
		random_phase(1024, 0, 40);
		random_phase(1024, 2047, 100);

		repeat (2000) @(posedge clk);
		if (n_errors == 0 && expected_rsps.size() == 0)
			$display("tb_buddy_page_allocator: PASS");
		else
			$display("tb_buddy_page_allocator: FAIL");
		$finish;
	end

endmodule
